// File: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int ROOT_WIDTH     = 25;
  localparam int QUEUE_DEPTH    = 4;

  // result classification
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_TWO    = 2'd2,
    KIND_DEGEN  = 2'd3
  } root_kind_t;

  // valid flag and class of one item moving between front and back
  typedef struct packed {
    logic       vld;
    root_kind_t kind;
  } tag_t;

endpackage

// File: rtl/core/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if
// Valid/ready channels for coefficient items and root items.
// ----------------------------------------------------------------------------
interface qrs_in_if #(parameter int COEF_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  root_kind;
  logic signed [24:0] root_first;
  logic signed [24:0] root_second;

  modport source (output valid, root_kind, root_first, root_second, input ready);
  modport sink (input valid, root_kind, root_first, root_second, output ready);
endinterface

// File: rtl/core/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient items, forms the discriminant and classifies the item.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  qrs_in_if.sink                       req,
  input  logic                         q_full,
  output tag_t                         push,
  output logic [2*COEF_WIDTH+1:0]      d_mag,
  output logic signed [COEF_WIDTH-1:0] a_out,
  output logic signed [COEF_WIDTH-1:0] b_out
);

  localparam int CW  = COEF_WIDTH;
  localparam int DW  = 2*CW + 3;
  localparam int DUW = DW - 1;

  logic                   en;
  logic                   v1;
  logic signed [CW-1:0]   a1;
  logic signed [CW-1:0]   b1;
  logic signed [2*CW-1:0] bb1;
  logic signed [2*CW-1:0] ac1;
  logic                   v2;
  root_kind_t             kind2;
  logic signed [DW-1:0]   d_c;
  root_kind_t             kind_c;

  assign en        = !v2 || !q_full;
  assign req.ready = en;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
    if (en) begin
      a1  <= req.coef_a;
      b1  <= req.coef_b;
      bb1 <= req.coef_b * req.coef_b;
      ac1 <= req.coef_a * req.coef_c;
    end
  end

  // discriminant and class
  always_comb begin
    d_c = DW'(bb1) - (DW'(ac1) <<< 2);
    if (a1 == '0) begin
      kind_c = KIND_DEGEN;
    end else if (d_c[DW-1]) begin
      kind_c = KIND_NONE;
    end else if (d_c == '0) begin
      kind_c = KIND_DOUBLE;
    end else begin
      kind_c = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      kind2 <= kind_c;
      d_mag <= (kind_c == KIND_TWO) ? d_c[DUW-1:0] : '0;
      a_out <= a1;
      b_out <= b1;
    end
  end

  assign push.vld  = v2 && !q_full;
  assign push.kind = kind2;

endmodule

// File: rtl/core/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module qrs_fifo import qrs_pkg::*; #(
  parameter int WIDTH = 66,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  tag_t             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output tag_t             head,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  root_kind_t       kmem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_pop;

  assign full      = (count == CNTW'(DEPTH));
  assign head.vld  = (count != '0);
  assign head.kind = kmem[rd_ptr];
  assign dout      = mem[rd_ptr];
  assign do_pop    = pop && head.vld;

  // storage
  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem[wr_ptr]  <= din;
      kmem[wr_ptr] <= push.kind;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.vld) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.vld && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.vld && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined square root, two pipelined dividers and the output register.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tag_t                         head,
  input  logic [2*COEF_WIDTH+1:0]      d_mag,
  input  logic signed [COEF_WIDTH-1:0] a_in,
  input  logic signed [COEF_WIDTH-1:0] b_in,
  output logic                         pop,
  qrs_out_if.source                    rsp
);

  localparam int CW   = COEF_WIDTH;
  localparam int DUW  = 2*CW + 2;
  localparam int RW   = DUW + 2*FRAC_BITS;
  localparam int RWE  = RW + (RW % 2);
  localparam int SW   = RWE / 2;
  localparam int NBM  = CW - 1 + FRAC_BITS;
  localparam int NW   = ((NBM > SW) ? NBM : SW) + 1;
  localparam int SNW  = NW + 1;
  localparam int QW   = ((NW > ROOT_WIDTH) ? NW : ROOT_WIDTH) + 1;
  localparam logic [QW-1:0] ROOT_LIM = QW'(1) << (ROOT_WIDTH - 1);
  localparam logic [QW-1:0] ROOT_MAX = ROOT_LIM - QW'(1);

  logic en;

  // square root pipeline, one root bit per stage
  logic                 sq_vld  [SW+1];
  root_kind_t           sq_kind [SW+1];
  logic [RWE-1:0]       sq_x    [SW+1];
  logic [SW-1:0]        sq_root [SW+1];
  logic [SW+1:0]        sq_rem  [SW+1];
  logic signed [CW-1:0] sq_a    [SW+1];
  logic signed [CW-1:0] sq_b    [SW+1];

  assign en  = !rsp.valid || rsp.ready;
  assign pop = en && head.vld;

  assign sq_vld[0]  = head.vld;
  assign sq_kind[0] = head.kind;
  assign sq_x[0]    = RWE'(d_mag) << (2*FRAC_BITS);
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_a[0]    = a_in;
  assign sq_b[0]    = b_in;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SW+1:0] rem_n;
    logic [SW+1:0] trial;
    logic          ge;

    always_comb begin
      rem_n = {sq_rem[k][SW-1:0], sq_x[k][RWE-1:RWE-2]};
      trial = {sq_root[k], 2'b01};
      ge    = (rem_n >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
      if (en) begin
        sq_kind[k+1] <= sq_kind[k];
        sq_x[k+1]    <= sq_x[k] << 2;
        sq_root[k+1] <= {sq_root[k][SW-2:0], ge};
        sq_rem[k+1]  <= ge ? rem_n - trial : rem_n;
        sq_a[k+1]    <= sq_a[k];
        sq_b[k+1]    <= sq_b[k];
      end
    end
  end

  // divider pipelines, one quotient bit per stage
  logic             dv_vld  [NW+1];
  root_kind_t       dv_kind [NW+1];
  logic [NW-1:0]    dv_n1   [NW+1];
  logic [NW-1:0]    dv_n2   [NW+1];
  logic [CW:0]      dv_r1   [NW+1];
  logic [CW:0]      dv_r2   [NW+1];
  logic [NW-1:0]    dv_q1   [NW+1];
  logic [NW-1:0]    dv_q2   [NW+1];
  logic             dv_ng1  [NW+1];
  logic             dv_ng2  [NW+1];
  logic [CW:0]      dv_den  [NW+1];

  // signed numerators and denominator magnitude
  logic signed [SNW-1:0] nb_c;
  logic signed [SNW-1:0] s_c;
  logic signed [SNW-1:0] n1_c;
  logic signed [SNW-1:0] n2_c;
  logic signed [CW+1:0]  den_c;
  logic signed [SNW-1:0] n1_abs;
  logic signed [SNW-1:0] n2_abs;
  logic signed [CW+1:0]  den_abs;

  always_comb begin
    nb_c    = -(SNW'(sq_b[SW]) <<< FRAC_BITS);
    s_c     = SNW'({1'b0, sq_root[SW]});
    n1_c    = nb_c + s_c;
    n2_c    = nb_c - s_c;
    den_c   = (CW+2)'(sq_a[SW]) <<< 1;
    n1_abs  = n1_c[SNW-1] ? -n1_c : n1_c;
    n2_abs  = n2_c[SNW-1] ? -n2_c : n2_c;
    den_abs = den_c[CW+1] ? -den_c : den_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SW];
    end
    if (en) begin
      dv_kind[0] <= sq_kind[SW];
      dv_n1[0]   <= n1_abs[NW-1:0];
      dv_n2[0]   <= n2_abs[NW-1:0];
      dv_r1[0]   <= '0;
      dv_r2[0]   <= '0;
      dv_q1[0]   <= '0;
      dv_q2[0]   <= '0;
      dv_ng1[0]  <= n1_c[SNW-1] ^ den_c[CW+1];
      dv_ng2[0]  <= n2_c[SNW-1] ^ den_c[CW+1];
      dv_den[0]  <= den_abs[CW:0];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [CW+1:0] r1_n;
    logic [CW+1:0] r2_n;
    logic [CW+1:0] den_x;
    logic          ge1;
    logic          ge2;
    logic [CW+1:0] r1_d;
    logic [CW+1:0] r2_d;

    always_comb begin
      den_x = {1'b0, dv_den[k]};
      r1_n  = {dv_r1[k], dv_n1[k][NW-1]};
      r2_n  = {dv_r2[k], dv_n2[k][NW-1]};
      ge1   = (r1_n >= den_x);
      ge2   = (r2_n >= den_x);
      r1_d  = ge1 ? r1_n - den_x : r1_n;
      r2_d  = ge2 ? r2_n - den_x : r2_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
      if (en) begin
        dv_kind[k+1] <= dv_kind[k];
        dv_n1[k+1]   <= dv_n1[k] << 1;
        dv_n2[k+1]   <= dv_n2[k] << 1;
        dv_r1[k+1]   <= r1_d[CW:0];
        dv_r2[k+1]   <= r2_d[CW:0];
        dv_q1[k+1]   <= {dv_q1[k][NW-2:0], ge1};
        dv_q2[k+1]   <= {dv_q2[k][NW-2:0], ge2};
        dv_ng1[k+1]  <= dv_ng1[k];
        dv_ng2[k+1]  <= dv_ng2[k];
        dv_den[k+1]  <= dv_den[k];
      end
    end
  end

  // apply sign and clamp to the root range
  function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [NW-1:0] q,
                                                     input logic neg);
    logic [QW-1:0] qx;
    logic [QW-1:0] qn;
    qx = QW'(q);
    qn = ~qx + QW'(1);
    if (neg) begin
      sat_root = (qx > ROOT_LIM) ? ROOT_LIM[ROOT_WIDTH-1:0] : qn[ROOT_WIDTH-1:0];
    end else begin
      sat_root = (qx > ROOT_MAX) ? ROOT_MAX[ROOT_WIDTH-1:0] : qx[ROOT_WIDTH-1:0];
    end
  endfunction

  logic has_roots;
  assign has_roots = (dv_kind[NW] == KIND_TWO) || (dv_kind[NW] == KIND_DOUBLE);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv_vld[NW];
    end
    if (en) begin
      rsp.root_kind   <= dv_kind[NW];
      rsp.root_first  <= has_roots ? sat_root(dv_q1[NW], dv_ng1[NW]) : '0;
      rsp.root_second <= has_roots ? sat_root(dv_q2[NW], dv_ng2[NW]) : '0;
    end
  end

endmodule

// File: rtl/core/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c in signed fixed point.
//
//   channel | dir | fields                               | handshake
//   req     | in  | coef_a, coef_b, coef_c               | valid/ready
//   rsp     | out | root_kind, root_first, root_second   | valid/ready
//
// One item per cycle sustained while results are taken; every item gives one result.
// The square root (SW bits) and the two dividers (NW quotient bits) are pipelined.
// Synchronous reset clears all valid flags and the queue.
// The front stalls only when the queue is full; the back stalls whenever the
// output register holds an item that is not taken.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  qrs_in_if.sink     req,
  qrs_out_if.source  rsp
);

  localparam int CW  = COEF_WIDTH;
  localparam int DUW = 2*CW + 2;
  localparam int QDW = DUW + 2*CW;

  tag_t                 push;
  tag_t                 head;
  logic                 q_full;
  logic                 pop;
  logic [DUW-1:0]       f_d;
  logic signed [CW-1:0] f_a;
  logic signed [CW-1:0] f_b;
  logic [QDW-1:0]       q_out;

  qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .d_mag  (f_d),
    .a_out  (f_a),
    .b_out  (f_b)
  );

  qrs_fifo #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({f_d, f_a, f_b}),
    .full (q_full),
    .pop  (pop),
    .head (head),
    .dout (q_out)
  );

  qrs_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .d_mag (q_out[QDW-1:2*CW]),
    .a_in  (q_out[2*CW-1:CW]),
    .b_in  (q_out[CW-1:0]),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// File: rtl/core/qrs_check.sv
// ----------------------------------------------------------------------------
// qrs_check
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_check import qrs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  root_kind,
  input logic [24:0] root_first,
  input logic [24:0] root_second
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(root_first) &&
      $stable(root_second) && $stable(root_kind))
    else $error("stalled result changed");

  // no roots or degenerate gives zero roots
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (root_kind == KIND_NONE || root_kind == KIND_DEGEN) |->
      root_first == '0 && root_second == '0)
    else $error("roots not zero");

  // double root fills both fields alike
  a_double: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && root_kind == KIND_DOUBLE |-> root_first == root_second)
    else $error("double root mismatch");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result after reset");

endmodule

bind quadratic_root_solver qrs_check u_qrs_check (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .root_kind   (rsp.root_kind),
  .root_first  (rsp.root_first),
  .root_second (rsp.root_second)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the quadratic root solver. A table of directed coefficient
// triples is followed by random triples mostly shaped toward double roots, two
// roots, no roots and a equal to zero. Each result is checked against a typed
// answer or an in-bench solver. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top;
  import qrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COEF_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint ROOT_HI = 64'sd16777215;
  localparam longint ROOT_LO = -64'sd16777216;
  localparam int N_RANDOM = 430;
  localparam int N_BURST = 100;

  typedef logic signed [CW-1:0] coef_t;
  typedef logic signed [ROOT_WIDTH-1:0] root_t;

  typedef struct {
    root_kind_t kind;
    root_t      first;
    root_t      second;
  } roots_t;

  typedef struct {
    coef_t  a, b, c;
    bit     typed;
    roots_t want;
  } row_t;

  logic clk;
  logic rst;

  qrs_in_if #(.COEF_WIDTH(CW)) req();
  qrs_out_if rsp();

  quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  roots_t pending_roots[$];
  int     errors = 0;
  int     sent = 0;
  int     got = 0;
  int     kind_seen[4] = '{0, 0, 0, 0};
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // truncating divide, clamped to the root range
  function automatic root_t div_root(longint num, longint den);
    longint q;
    q = num / den;
    if (q > ROOT_HI) q = ROOT_HI;
    if (q < ROOT_LO) q = ROOT_LO;
    return root_t'(q);
  endfunction

  // real roots of a*x^2 + b*x + c in fixed point
  function automatic roots_t solve_roots(coef_t a, coef_t b, coef_t c);
    roots_t r;
    longint aa, bb, cc, disc, den, nb;
    longint unsigned x, acc, bitv;
    aa = a;
    bb = b;
    cc = c;
    r.kind = KIND_NONE;
    r.first = '0;
    r.second = '0;
    if (aa == 0) begin
      r.kind = KIND_DEGEN;
      return r;
    end
    disc = bb * bb - 4 * aa * cc;
    if (disc < 0) return r;
    // floor square root of the discriminant scaled by 2*FB bits
    x = longint'(disc) << (2 * FB);
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= acc + bitv) begin
        x = x - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    den = 2 * aa;
    nb = -(bb * (64'sd1 << FB));
    if (disc == 0) begin
      r.kind = KIND_DOUBLE;
      r.first = div_root(nb, den);
      r.second = r.first;
    end else begin
      r.kind = KIND_TWO;
      r.first = div_root(nb + longint'(acc), den);
      r.second = div_root(nb - longint'(acc), den);
    end
    return r;
  endfunction

  // offer one item and hold it until taken; expectation is queued on accept
  task automatic send_coefs(coef_t a, coef_t b, coef_t c, bit typed, roots_t want);
    // random gap before the item
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req.valid  <= 1'b1;
    req.coef_a <= a;
    req.coef_b <= b;
    req.coef_c <= c;
    do @(posedge clk); while (!req.ready);
    pending_roots.push_back(typed ? want : solve_roots(a, b, c));
    sent++;
  endtask

  // random coefficient triple, biased toward each class of result
  task automatic random_coefs(output coef_t a, output coef_t b, output coef_t c);
    int sel;
    int ra, rr;
    sel = $urandom_range(99);
    a = coef_t'($urandom);
    b = coef_t'($urandom);
    c = coef_t'($urandom);
    if (sel < 20) begin
      // double root: b = -2ar, c = ar^2
      ra = $urandom_range(40) - 20;
      if (ra == 0) ra = 1;
      rr = $urandom_range(40) - 20;
      a = coef_t'(ra);
      b = coef_t'(-2 * ra * rr);
      c = coef_t'(ra * rr * rr);
    end else if (sel < 30) begin
      a = '0;
    end else if (sel < 60) begin
      a = coef_t'($urandom_range(255) - 128);
      b = coef_t'($urandom_range(511) - 256);
      c = coef_t'($urandom_range(255) - 128);
      if (a == 0) a = 1;
    end
  endtask

  // receiver: check each taken item, then choose ready for the next edge
  always @(posedge clk) begin
    roots_t w;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got++;
        if (pending_roots.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d first=%0d second=%0d",
                   $time, rsp.root_kind, rsp.root_first, rsp.root_second);
        end else begin
          w = pending_roots.pop_front();
          kind_seen[w.kind]++;
          if (rsp.root_kind !== w.kind) begin
            errors++;
            $display("%0t: root_kind expected %0d actual %0d", $time, w.kind, rsp.root_kind);
          end
          if (rsp.root_first !== w.first) begin
            errors++;
            $display("%0t: root_first expected %0d actual %0d", $time, w.first,
                     rsp.root_first);
          end
          if (rsp.root_second !== w.second) begin
            errors++;
            $display("%0t: root_second expected %0d actual %0d", $time, w.second,
                     rsp.root_second);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    row_t rows[$];
    row_t r;
    coef_t a, b, c;
    roots_t none;
    int phase;
    none.kind = KIND_NONE;
    none.first = '0;
    none.second = '0;

    // directed table: typed rows where the answer is plain
    r.typed = 1'b1;
    r.want = none;
    r.want.kind = KIND_DEGEN;
    r.a = 0;       r.b = 0;       r.c = 0;       rows.push_back(r);
    r.a = 0;       r.b = 32767;   r.c = -32768;  rows.push_back(r);
    r.a = 0;       r.b = -32768;  r.c = 32767;   rows.push_back(r);
    r.want = none;
    r.a = 1;       r.b = 0;       r.c = 1;       rows.push_back(r);
    r.a = 32767;   r.b = 0;       r.c = 32767;   rows.push_back(r);
    r.a = -32768;  r.b = 1;       r.c = -32768;  rows.push_back(r);
    r.want.kind = KIND_DOUBLE;
    r.want.first = 256;  r.want.second = 256;
    r.a = 1;       r.b = -2;      r.c = 1;       rows.push_back(r);
    r.want.first = 0;    r.want.second = 0;
    r.a = 5;       r.b = 0;       r.c = 0;       rows.push_back(r);
    r.want.kind = KIND_TWO;
    r.want.first = 256;  r.want.second = -256;
    r.a = 1;       r.b = 0;       r.c = -1;      rows.push_back(r);
    // predicted rows: extremes and sign mixes
    r.typed = 1'b0;
    r.a = -32768;  r.b = -32768;  r.c = 32767;   rows.push_back(r);
    r.a = 32767;   r.b = -32768;  r.c = -32768;  rows.push_back(r);
    r.a = 1;       r.b = -32768;  r.c = -32768;  rows.push_back(r);
    r.a = 1;       r.b = 32767;   r.c = 0;       rows.push_back(r);
    r.a = -1;      r.b = 32767;   r.c = 32767;   rows.push_back(r);
    r.a = -32768;  r.b = 0;       r.c = 32767;   rows.push_back(r);
    r.a = 32767;   r.b = 32767;   r.c = -1;      rows.push_back(r);
    r.a = -1;      r.b = -1;      r.c = 0;       rows.push_back(r);
    r.a = 3;       r.b = 7;       r.c = -11;     rows.push_back(r);
    r.a = -7;      r.b = 5;       r.c = 13;      rows.push_back(r);
    r.a = 2;       r.b = 3;       r.c = 1;       rows.push_back(r);

    req.valid = 1'b0;
    req.coef_a = '0;
    req.coef_b = '0;
    req.coef_c = '0;
    rsp.ready = 1'b0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed,
                                 rows[i].want);

    // long receiver hold while items keep coming, more than the block holds,
    // so the input backs up
    idle_pct = 0;
    hold_left = 300;
    repeat (N_BURST) begin
      random_coefs(a, b, c);
      send_coefs(a, b, c, 1'b0, none);
    end
    // sender waits for every result before going on
    req.valid <= 1'b0;
    wait (pending_roots.size() == 0);
    @(posedge clk);

    // random phases: none, sender gaps, receiver stalls, both
    for (int i = 0; i < N_RANDOM - N_BURST; i++) begin
      phase = (i / 40) % 5;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        3: begin idle_pct = 12; stall_pct = 12; end
        default: begin idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
      endcase
      random_coefs(a, b, c);
      send_coefs(a, b, c, 1'b0, none);
    end
    req.valid <= 1'b0;
    stall_pct = 0;

    wait (pending_roots.size() == 0);
    repeat (100) @(posedge clk);
    $display("sent %0d triples, checked %0d results", sent, got);
    $display("kinds seen: none %0d, double %0d, two %0d, degenerate %0d",
             kind_seen[KIND_NONE], kind_seen[KIND_DOUBLE], kind_seen[KIND_TWO],
             kind_seen[KIND_DEGEN]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
